// ----- rtl/core/utf8_stream_decoder_core_assert.svh -----
// ----------------------------------------------------------------------------
// UTF-8 stream decoder assertion macros
// Shared concurrent assertion forms used by the decoder core.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_CORE_ASSERT_SVH
`define UTF8_STREAM_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define U8SD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define U8SD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/utf8d_pkg.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Shared constants and the work descriptor passed from front to back.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] CONT_LO   = 8'h80;
  localparam logic [7:0] CONT_HI   = 8'hBF;
  localparam logic [7:0] LEAD_MIN  = 8'hC2;
  localparam logic [7:0] LEAD_E0   = 8'hE0;
  localparam logic [7:0] LEAD_ED   = 8'hED;
  localparam logic [7:0] LEAD_F0   = 8'hF0;
  localparam logic [7:0] LEAD_F4   = 8'hF4;
  localparam logic [7:0] LEAD_BAD  = 8'hF5;
  localparam logic [7:0] E0_LO     = 8'hA0;
  localparam logic [7:0] ED_HI     = 8'h9F;
  localparam logic [7:0] F0_LO     = 8'h90;
  localparam logic [7:0] F4_HI     = 8'h8F;

  // One input byte's results: n_err error beats, then an optional valid beat.
  typedef struct packed {
    logic [2:0]  n_err;
    logic        has_valid;
    logic [20:0] cp;
    logic [2:0]  len;
  } job_t;

endpackage

// ----- rtl/core/utf8d_front.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decoder front end
// Accepts bytes, tracks the open sequence and builds one job for each byte that yields results.
// ----------------------------------------------------------------------------
module utf8d_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data_byte,
  input  logic              in_final_byte,
  input  logic              q_full,
  output logic              push,
  output utf8d_pkg::job_t   job
);
  import utf8d_pkg::*;

  logic [7:0]  lead_r, lead_nxt;
  logic [2:0]  exp_r, exp_nxt;
  logic [1:0]  seen_r, seen_nxt;
  logic [20:0] part_r, part_nxt;
  logic [7:0]  lo, hi;
  logic [2:0]  seen_inc;
  logic [20:0] part_shift;
  logic        do_start;
  logic        accept;

  assign in_ready   = !q_full;
  assign accept     = in_valid && in_ready;
  assign part_shift = {part_r[14:0], in_data_byte[5:0]};
  assign seen_inc   = {1'b0, seen_r} + 3'd1;

  always_comb begin
    lead_nxt = lead_r;
    exp_nxt  = exp_r;
    seen_nxt = seen_r;
    part_nxt = part_r;
    job      = '0;
    job.len  = 3'd1;
    lo       = CONT_LO;
    hi       = CONT_HI;
    do_start = 1'b0;
    if (seen_r == 2'd1) begin
      case (lead_r)
        LEAD_E0: lo = E0_LO;
        LEAD_ED: hi = ED_HI;
        LEAD_F0: lo = F0_LO;
        LEAD_F4: hi = F4_HI;
        default: ;
      endcase
    end
    if (exp_r == 3'd0) begin
      do_start = 1'b1;
    end else if (in_data_byte inside {[lo:hi]}) begin
      if (seen_inc >= exp_r) begin
        job.has_valid = 1'b1;
        job.cp        = part_shift;
        job.len       = exp_r;
        lead_nxt      = '0;
        exp_nxt       = '0;
        seen_nxt      = '0;
        part_nxt      = '0;
      end else begin
        seen_nxt = seen_inc[1:0];
        part_nxt = part_shift;
      end
    end else begin
      job.n_err = {1'b0, seen_r};
      lead_nxt  = '0;
      exp_nxt   = '0;
      seen_nxt  = '0;
      part_nxt  = '0;
      do_start  = 1'b1;
    end
    if (do_start) begin
      if (!in_data_byte[7]) begin
        job.has_valid = 1'b1;
        job.cp        = {13'd0, in_data_byte};
        job.len       = 3'd1;
      end else if (in_data_byte < LEAD_MIN || in_data_byte >= LEAD_BAD) begin
        job.n_err = job.n_err + 3'd1;
      end else begin
        lead_nxt = in_data_byte;
        seen_nxt = 2'd1;
        if (in_data_byte < LEAD_E0) begin
          exp_nxt  = 3'd2;
          part_nxt = {16'd0, in_data_byte[4:0]};
        end else if (in_data_byte < LEAD_F0) begin
          exp_nxt  = 3'd3;
          part_nxt = {17'd0, in_data_byte[3:0]};
        end else begin
          exp_nxt  = 3'd4;
          part_nxt = {18'd0, in_data_byte[2:0]};
        end
      end
    end
    if (in_final_byte && exp_nxt != 3'd0) begin
      job.n_err = job.n_err + {1'b0, seen_nxt};
      lead_nxt  = '0;
      exp_nxt   = '0;
      seen_nxt  = '0;
      part_nxt  = '0;
    end
  end

  assign push = accept && (job.n_err != 3'd0 || job.has_valid);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r <= '0;
      exp_r  <= '0;
      seen_r <= '0;
      part_r <= '0;
    end else if (accept) begin
      lead_r <= lead_nxt;
      exp_r  <= exp_nxt;
      seen_r <= seen_nxt;
      part_r <= part_nxt;
    end
  end

endmodule

// ----- rtl/core/utf8d_fifo.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decoder job queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module utf8d_fifo #(
  parameter int unsigned DEPTH = utf8d_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  utf8d_pkg::job_t   push_job,
  input  logic              pop,
  output utf8d_pkg::job_t   head_job,
  output logic              full,
  output logic              empty
);
  import utf8d_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ----- rtl/core/utf8d_back.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decoder back end
// Expands the job at the queue head into one result beat per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module utf8d_back (
  input  logic              clk,
  input  logic              rst_n,
  input  utf8d_pkg::job_t   head_job,
  input  logic              q_empty,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [20:0]       out_code_point,
  output logic              out_is_valid,
  output logic [2:0]        out_seq_length,
  output logic              out_run_end
);
  import utf8d_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic [2:0] total;
  logic       last;
  logic       beat_ok;

  assign total     = head_job.n_err + {2'b00, head_job.has_valid};
  assign last      = ({1'b0, idx_r} == (total - 3'd1));
  assign beat_ok   = last && head_job.has_valid;
  assign out_valid = !q_empty;
  assign pop       = out_valid && out_ready && last;

  assign out_code_point = beat_ok ? head_job.cp : '0;
  assign out_is_valid   = beat_ok;
  assign out_seq_length = beat_ok ? head_job.len : 3'd1;
  assign out_run_end    = last;

  always_comb begin
    idx_nxt = idx_r;
    if (out_valid && out_ready) begin
      idx_nxt = last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

// ----- rtl/core/utf8_stream_decoder_core.sv -----
// ----------------------------------------------------------------------------
// UTF-8 stream decoder core
// Strict streaming UTF-8 decoder with a decoupled front end and back end.
// ----------------------------------------------------------------------------
// The core takes one byte per cycle whenever its job queue has room, and
// sends one result beat per cycle while out_ready is high. Each byte with
// results becomes one job holding one to four of them; a byte with N results
// occupies the back end for N result beats, so a run of error bursts is
// absorbed by the QUEUE_DEPTH-entry job queue and throttles the input only
// once that queue is full. A result appears once its job is at the queue head,
// at the earliest from the cycle after its byte is accepted. No clearing pass follows reset.
`include "utf8_stream_decoder_core_assert.svh"

module utf8_stream_decoder_core #(
  parameter int unsigned QUEUE_DEPTH = utf8d_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] out_code_point,
  output logic        out_is_valid,
  output logic [2:0]  out_seq_length,
  output logic        out_run_end
);
  import utf8d_pkg::*;

  job_t push_job;
  job_t head_job;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  utf8d_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_final_byte (in_final_byte),
    .q_full        (q_full),
    .push          (push),
    .job           (push_job)
  );

  utf8d_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  utf8d_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_job       (head_job),
    .q_empty        (q_empty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code_point (out_code_point),
    .out_is_valid   (out_is_valid),
    .out_seq_length (out_seq_length),
    .out_run_end    (out_run_end)
  );

  `U8SD_ASSERT_SAME(a_push_not_full, clk, rst_n, push, !q_full, "Job pushed into a full queue")
  `U8SD_ASSERT_SAME(a_valid_ends_run, clk, rst_n, out_valid && out_is_valid, out_run_end, "Valid beat is not the last of its run")
  `U8SD_ASSERT_SAME(a_error_shape, clk, rst_n, out_valid && !out_is_valid, out_code_point == 21'd0 && out_seq_length == 3'd1, "Error beat carries a value or length")
  `U8SD_ASSERT_NEXT(a_push_shows, clk, rst_n, push, out_valid, "Queued job not presented at the output")

endmodule
